>>> hdl/pmtpp_pkg.sv
// Shared types and constants for the program map section PID parser.
package pmtpp_pkg;

    localparam int PID_W  = 13;
    localparam int LANG_W = 24;

    // Parse phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LEN     = 3'd1,
        PH_HDR     = 3'd2,
        PH_PI_TAG  = 3'd3,
        PH_PI_LEN  = 3'd4,
        PH_PI_BODY = 3'd5,
        PH_ES_HDR  = 3'd6,
        PH_ES_DESC = 3'd7
    } t_phase;

    // Stream types
    localparam logic [7:0] ST_MPEG1_VIDEO = 8'h01;
    localparam logic [7:0] ST_MPEG2_VIDEO = 8'h02;
    localparam logic [7:0] ST_MPEG1_AUDIO = 8'h03;
    localparam logic [7:0] ST_MPEG2_AUDIO = 8'h04;
    localparam logic [7:0] ST_AC3         = 8'h81;

    // Descriptor tags
    localparam logic [7:0] TAG_LANG = 8'h0A;
    localparam logic [7:0] TAG_TTX  = 8'h56;
    localparam logic [7:0] TAG_AC3  = 8'h6A;

    // Field masks
    localparam logic [7:0] MASK_PID_HI = 8'h1F;
    localparam logic [7:0] MASK_LEN_HI = 8'h0F;

    // Held PID slots
    localparam logic [2:0] SLOT_VIDEO  = 3'd0;
    localparam logic [2:0] SLOT_AUDIO1 = 3'd1;
    localparam logic [2:0] SLOT_AUDIO2 = 3'd2;
    localparam logic [2:0] SLOT_AUDIO3 = 3'd3;
    localparam logic [2:0] SLOT_AC3    = 3'd4;
    localparam logic [2:0] SLOT_TTX    = 3'd5;
    localparam logic [2:0] SLOT_PCR    = 3'd6;
    localparam int         NUM_SLOTS   = 7;
    localparam int         NUM_LANGS   = 3;

    // Result word
    typedef struct packed {
        logic [PID_W-1:0]  video_pid;
        logic [PID_W-1:0]  audio_pid_first;
        logic [PID_W-1:0]  audio_pid_second;
        logic [PID_W-1:0]  audio_pid_third;
        logic [PID_W-1:0]  ac3_pid;
        logic [PID_W-1:0]  teletext_pid;
        logic [PID_W-1:0]  clock_ref_pid;
        logic [LANG_W-1:0] lang_first;
        logic [LANG_W-1:0] lang_second;
        logic [LANG_W-1:0] lang_third;
        logic              more_sections;
        logic [7:0]        next_section;
    } t_record;

endpackage

>>> hdl/pmtpp_parse.sv
// Section parse state, held PID/language record and per-byte update logic.
module pmtpp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_command,
    input  logic [7:0]          i_data_byte,
    input  logic                i_section_start,
    output logic                o_emit,
    output pmtpp_pkg::t_record  o_rec
);

    // header byte offsets after the length field
    localparam logic [11:0] HDR_SECT_NUM = 12'd3;
    localparam logic [11:0] HDR_LAST_NUM = 12'd4;
    localparam logic [11:0] HDR_PCR_HI   = 12'd5;
    localparam logic [11:0] HDR_PCR_LO   = 12'd6;
    localparam logic [11:0] HDR_PIL_HI   = 12'd7;
    localparam logic [11:0] HDR_PIL_LO   = 12'd8;

    logic [11:0]                   r_pos, n_pos;
    logic [11:0]                   r_len, n_len;
    pmtpp_pkg::t_phase             r_phase, n_phase;
    logic [11:0]                   r_fc, n_fc;
    logic [7:0]                    r_type, n_type;
    logic [pmtpp_pkg::PID_W-1:0]   r_pid, n_pid;
    logic [11:0]                   r_info, n_info;
    logic [7:0]                    r_tag, n_tag;
    logic [7:0]                    r_dleft, n_dleft;
    logic [1:0]                    r_slot, n_slot;
    logic [7:0]                    r_sect, n_sect;
    logic [7:0]                    r_last, n_last;
    logic [pmtpp_pkg::PID_W-1:0]   r_pcr, n_pcr;
    logic [pmtpp_pkg::PID_W-1:0]   r_held [pmtpp_pkg::NUM_SLOTS];
    logic [pmtpp_pkg::PID_W-1:0]   n_held [pmtpp_pkg::NUM_SLOTS];
    logic [pmtpp_pkg::LANG_W-1:0]  r_lang [pmtpp_pkg::NUM_LANGS];
    logic [pmtpp_pkg::LANG_W-1:0]  n_lang [pmtpp_pkg::NUM_LANGS];

    logic body_ok;
    logic last_byte;

    function automatic logic [11:0] sat_sub(input logic [11:0] a, input logic [7:0] v);
        logic [11:0] need;
        begin
            need = {4'h0, v} + 12'd2;
            sat_sub = (a > need) ? (a - need) : 12'd0;
        end
    endfunction

    assign body_ok   = ({1'b0, r_pos} + 13'd4) < {1'b0, r_len};
    assign last_byte = ({1'b0, r_pos} + 13'd1) >= {1'b0, r_len};

    // emit flag for the byte in the input register
    always_comb begin
        o_emit = 1'b0;
        if (!i_command && !i_section_start) begin
            if (r_phase == pmtpp_pkg::PH_LEN) begin
                o_emit = (r_pos != 12'd1) && ((r_len | {4'h0, i_data_byte}) == 12'd0);
            end else if (r_phase != pmtpp_pkg::PH_IDLE) begin
                o_emit = last_byte;
            end
        end
    end

    always_comb begin
        o_rec.video_pid        = r_held[pmtpp_pkg::SLOT_VIDEO];
        o_rec.audio_pid_first  = r_held[pmtpp_pkg::SLOT_AUDIO1];
        o_rec.audio_pid_second = r_held[pmtpp_pkg::SLOT_AUDIO2];
        o_rec.audio_pid_third  = r_held[pmtpp_pkg::SLOT_AUDIO3];
        o_rec.ac3_pid          = r_held[pmtpp_pkg::SLOT_AC3];
        o_rec.teletext_pid     = r_held[pmtpp_pkg::SLOT_TTX];
        o_rec.clock_ref_pid    = r_held[pmtpp_pkg::SLOT_PCR];
        o_rec.lang_first       = r_lang[0];
        o_rec.lang_second      = r_lang[1];
        o_rec.lang_third       = r_lang[2];
        o_rec.more_sections    = r_last > r_sect;
        o_rec.next_section     = (r_last > r_sect) ? (r_sect + 8'd1) : 8'd0;
    end

    // next state, phase included
    always_comb begin
        logic [7:0]  v;
        logic [11:0] k;
        logic [1:0]  li;
        v       = i_data_byte;
        k       = r_fc - 12'd2;
        li      = r_slot - 2'd1;
        n_pos   = r_pos;
        n_len   = r_len;
        n_phase = r_phase;
        n_fc    = r_fc;
        n_type  = r_type;
        n_pid   = r_pid;
        n_info  = r_info;
        n_tag   = r_tag;
        n_dleft = r_dleft;
        n_slot  = r_slot;
        n_sect  = r_sect;
        n_last  = r_last;
        n_pcr   = r_pcr;
        n_held  = r_held;
        n_lang  = r_lang;

        if (i_fire) begin
            if (i_command) begin
                n_held = '{default: '0};
                n_lang = '{default: '0};
            end else if (i_section_start) begin
                n_pos   = 12'd1;
                n_len   = 12'd0;
                n_phase = pmtpp_pkg::PH_LEN;
                n_fc    = 12'd0;
                n_type  = 8'd0;
                n_pid   = '0;
                n_info  = 12'd0;
                n_tag   = 8'd0;
                n_dleft = 8'd0;
                n_slot  = 2'd0;
                n_sect  = 8'd0;
                n_last  = 8'd0;
                n_pcr   = '0;
            end else if (r_phase == pmtpp_pkg::PH_LEN) begin
                if (r_pos == 12'd1) begin
                    n_len = {v[3:0] & pmtpp_pkg::MASK_LEN_HI[3:0], 8'h00};
                    n_pos = 12'd2;
                end else begin
                    n_len   = r_len | {4'h0, v};
                    n_pos   = 12'd0;
                    n_phase = (n_len == 12'd0) ? pmtpp_pkg::PH_IDLE : pmtpp_pkg::PH_HDR;
                end
            end else if (r_phase != pmtpp_pkg::PH_IDLE) begin
                if (body_ok) begin
                    case (r_phase)
                        pmtpp_pkg::PH_HDR: begin
                            case (r_pos)
                                HDR_SECT_NUM: n_sect = v;
                                HDR_LAST_NUM: n_last = v;
                                HDR_PCR_HI:   n_pcr = {v[4:0] & pmtpp_pkg::MASK_PID_HI[4:0], 8'h00};
                                HDR_PCR_LO:   n_pcr = r_pcr | {5'h00, v};
                                HDR_PIL_HI:   n_fc = {v[3:0] & pmtpp_pkg::MASK_LEN_HI[3:0], 8'h00};
                                HDR_PIL_LO: begin
                                    n_fc    = r_fc | {4'h0, v};
                                    n_phase = (n_fc != 12'd0) ? pmtpp_pkg::PH_PI_TAG
                                                              : pmtpp_pkg::PH_ES_HDR;
                                end
                                default: ;
                            endcase
                        end
                        pmtpp_pkg::PH_PI_TAG: begin
                            n_phase = pmtpp_pkg::PH_PI_LEN;
                        end
                        pmtpp_pkg::PH_PI_LEN: begin
                            n_dleft = v;
                            n_fc    = sat_sub(r_fc, v);
                            if (v == 8'd0) begin
                                n_phase = (n_fc == 12'd0) ? pmtpp_pkg::PH_ES_HDR
                                                          : pmtpp_pkg::PH_PI_TAG;
                            end else begin
                                n_phase = pmtpp_pkg::PH_PI_BODY;
                            end
                        end
                        pmtpp_pkg::PH_PI_BODY: begin
                            n_dleft = r_dleft - 8'd1;
                            if (n_dleft == 8'd0) begin
                                n_phase = (r_fc == 12'd0) ? pmtpp_pkg::PH_ES_HDR
                                                          : pmtpp_pkg::PH_PI_TAG;
                            end
                        end
                        pmtpp_pkg::PH_ES_HDR: begin
                            case (r_fc)
                                12'd0: begin
                                    n_type = v;
                                    n_fc   = r_fc + 12'd1;
                                end
                                12'd1: begin
                                    n_pid = {v[4:0] & pmtpp_pkg::MASK_PID_HI[4:0], 8'h00};
                                    n_fc  = r_fc + 12'd1;
                                end
                                12'd2: begin
                                    n_pid = r_pid | {5'h00, v};
                                    n_fc  = r_fc + 12'd1;
                                end
                                12'd3: begin
                                    n_info = {v[3:0] & pmtpp_pkg::MASK_LEN_HI[3:0], 8'h00};
                                    n_fc   = r_fc + 12'd1;
                                end
                                default: begin
                                    // entry header complete
                                    n_info = r_info | {4'h0, v};
                                    if ((r_type == pmtpp_pkg::ST_MPEG1_VIDEO ||
                                         r_type == pmtpp_pkg::ST_MPEG2_VIDEO) &&
                                        r_held[pmtpp_pkg::SLOT_VIDEO] == '0) begin
                                        n_held[pmtpp_pkg::SLOT_VIDEO] = r_pid;
                                    end
                                    if (r_type == pmtpp_pkg::ST_MPEG1_AUDIO ||
                                        r_type == pmtpp_pkg::ST_MPEG2_AUDIO) begin
                                        n_slot = 2'd0;
                                        if (r_held[pmtpp_pkg::SLOT_AUDIO1] == '0) begin
                                            n_held[pmtpp_pkg::SLOT_AUDIO1] = r_pid;
                                            n_slot = 2'd1;
                                        end else if (r_held[pmtpp_pkg::SLOT_AUDIO2] == '0) begin
                                            n_held[pmtpp_pkg::SLOT_AUDIO2] = r_pid;
                                            n_slot = 2'd2;
                                        end else if (r_held[pmtpp_pkg::SLOT_AUDIO3] == '0) begin
                                            n_held[pmtpp_pkg::SLOT_AUDIO3] = r_pid;
                                            n_slot = 2'd3;
                                        end
                                    end
                                    n_held[pmtpp_pkg::SLOT_PCR] = r_pcr;
                                    if (r_type == pmtpp_pkg::ST_AC3 &&
                                        r_held[pmtpp_pkg::SLOT_AC3] == '0) begin
                                        n_held[pmtpp_pkg::SLOT_AC3] = r_pid;
                                    end
                                    n_fc    = 12'd0;
                                    n_phase = (n_info != 12'd0) ? pmtpp_pkg::PH_ES_DESC
                                                                : pmtpp_pkg::PH_ES_HDR;
                                end
                            endcase
                        end
                        pmtpp_pkg::PH_ES_DESC: begin
                            if (r_fc == 12'd0) begin
                                n_tag = v;
                                if (v == pmtpp_pkg::TAG_AC3) begin
                                    n_held[pmtpp_pkg::SLOT_AC3] = r_pid;
                                end
                                if (v == pmtpp_pkg::TAG_TTX &&
                                    r_held[pmtpp_pkg::SLOT_TTX] == '0) begin
                                    n_held[pmtpp_pkg::SLOT_TTX] = r_pid;
                                end
                                n_fc = 12'd1;
                            end else if (r_fc == 12'd1) begin
                                n_dleft = v;
                                n_info  = sat_sub(r_info, v);
                                if (v == 8'd0) begin
                                    if (n_info == 12'd0) begin
                                        n_phase = pmtpp_pkg::PH_ES_HDR;
                                    end
                                    n_fc = 12'd0;
                                end else begin
                                    n_fc = 12'd2;
                                end
                            end else begin
                                // descriptor body; language bytes to the last filled audio slot
                                if (r_tag == pmtpp_pkg::TAG_LANG && k < 12'd3 &&
                                    r_slot != 2'd0) begin
                                    case (k[1:0])
                                        2'd0:    n_lang[li][23:16] = v;
                                        2'd1:    n_lang[li][15:8]  = v;
                                        default: n_lang[li][7:0]   = v;
                                    endcase
                                end
                                n_dleft = r_dleft - 8'd1;
                                if (n_dleft == 8'd0) begin
                                    if (r_info == 12'd0) begin
                                        n_phase = pmtpp_pkg::PH_ES_HDR;
                                    end
                                    n_fc = 12'd0;
                                end else begin
                                    n_fc = r_fc + 12'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                if (last_byte) begin
                    n_phase = pmtpp_pkg::PH_IDLE;
                end else begin
                    n_pos = r_pos + 12'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 12'd0;
            r_len   <= 12'd0;
            r_phase <= pmtpp_pkg::PH_IDLE;
            r_fc    <= 12'd0;
            r_type  <= 8'd0;
            r_pid   <= '0;
            r_info  <= 12'd0;
            r_tag   <= 8'd0;
            r_dleft <= 8'd0;
            r_slot  <= 2'd0;
            r_sect  <= 8'd0;
            r_last  <= 8'd0;
            r_pcr   <= '0;
            r_held  <= '{default: '0};
            r_lang  <= '{default: '0};
        end else begin
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_phase <= n_phase;
            r_fc    <= n_fc;
            r_type  <= n_type;
            r_pid   <= n_pid;
            r_info  <= n_info;
            r_tag   <= n_tag;
            r_dleft <= n_dleft;
            r_slot  <= n_slot;
            r_sect  <= n_sect;
            r_last  <= n_last;
            r_pcr   <= n_pcr;
            r_held  <= n_held;
            r_lang  <= n_lang;
        end
    end

`ifndef ASSERT_OFF
    // body bytes never run past the section end
    a_pos_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != pmtpp_pkg::PH_IDLE && r_phase != pmtpp_pkg::PH_LEN) |-> (r_pos < r_len))
        else $error("byte position past section length");

    a_len_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pmtpp_pkg::PH_LEN) |-> (r_pos == 12'd1 || r_pos == 12'd2))
        else $error("bad position in length phase");

    a_es_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pmtpp_pkg::PH_ES_HDR) |-> (r_fc <= 12'd4))
        else $error("entry header counter overrun");

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_emit) |=> (r_phase == pmtpp_pkg::PH_IDLE))
        else $error("parse not idle after section end");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_command) |=> (r_held[pmtpp_pkg::SLOT_VIDEO] == '0 && r_lang[0] == '0))
        else $error("record not cleared");
`endif

endmodule

>>> hdl/pmt_section_pid_parser_unit.sv
// Top level of the program map section PID parser: handshakes and word registers.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_command, i_data_byte, i_section_start
//  out     | from block| o_out_valid / i_out_stall| PIDs, language codes, section numbers
//
// One input word per cycle is sustained unless a section-end word stalls. A word
// waits in the input register; when it is processed the parse logic updates its state and,
// on the section's last byte, loads the output register, so a result is registered
// there after its last byte leaves the input register. Synchronous active-low reset
// clears the parse state and the held record. The input register keeps moving while
// a result waits downstream; only a section-end word stalls, and only while the output is held.

module pmt_section_pid_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    input  logic        i_section_start,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [12:0] o_video_pid,
    output logic [12:0] o_audio_pid_first,
    output logic [12:0] o_audio_pid_second,
    output logic [12:0] o_audio_pid_third,
    output logic [12:0] o_ac3_pid,
    output logic [12:0] o_teletext_pid,
    output logic [12:0] o_clock_ref_pid,
    output logic [23:0] o_lang_first,
    output logic [23:0] o_lang_second,
    output logic [23:0] o_lang_third,
    output logic        o_more_sections,
    output logic [7:0]  o_next_section
);

    // input word register
    logic               r_in_valid, n_in_valid;
    logic               r_in_command;
    logic [7:0]         r_in_data;
    logic               r_in_start;

    // result word register
    logic               r_out_valid, n_out_valid;
    pmtpp_pkg::t_record r_out_rec;

    logic               w_emit;
    logic               w_advance;
    logic               w_accept;
    pmtpp_pkg::t_record w_rec;

    pmtpp_parse u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_advance),
        .i_command       (r_in_command),
        .i_data_byte     (r_in_data),
        .i_section_start (r_in_start),
        .o_emit          (w_emit),
        .o_rec           (w_rec)
    );

    // the held word is processed unless it ends a section and the output is blocked
    assign w_advance  = r_in_valid && (!w_emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance && w_emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_command <= i_command;
            r_in_data    <= i_data_byte;
            r_in_start   <= i_section_start;
        end
        if (w_advance && w_emit) begin
            r_out_rec <= w_rec;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_video_pid        = r_out_rec.video_pid;
    assign o_audio_pid_first  = r_out_rec.audio_pid_first;
    assign o_audio_pid_second = r_out_rec.audio_pid_second;
    assign o_audio_pid_third  = r_out_rec.audio_pid_third;
    assign o_ac3_pid          = r_out_rec.ac3_pid;
    assign o_teletext_pid     = r_out_rec.teletext_pid;
    assign o_clock_ref_pid    = r_out_rec.clock_ref_pid;
    assign o_lang_first       = r_out_rec.lang_first;
    assign o_lang_second      = r_out_rec.lang_second;
    assign o_lang_third       = r_out_rec.lang_third;
    assign o_more_sections    = r_out_rec.more_sections;
    assign o_next_section     = r_out_rec.next_section;

endmodule
